// ===== design/fdss_pkg.sv =====
package fdss_pkg;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned SEG_W       = 7;
  localparam int unsigned EN_W        = 4;
  localparam int unsigned COUNT_W     = 14;
  localparam int unsigned DWELL_W     = 8;
  localparam int unsigned BCD_DIGITS  = 4;
  localparam int unsigned PROD_W      = 18;
  localparam int unsigned POS_W       = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 14'd9999;
  localparam logic [DWELL_W-1:0] DWELL_MIN  = 8'd6;
  localparam logic [PROD_W-1:0]  DWELL_SPAN = 18'd249;

  // Item kinds on the input channel.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_PRESS = 1'b1;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [BCD_DIGITS-1:0] bcd_t;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin;
    bcd_t               bcd;
  } count_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
  } disp_t;

  // Standard seven-segment patterns, bit 0 = a through bit 6 = g.
  function automatic logic [SEG_W-1:0] seg_decode(input bcd_digit_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== design/fdss_in_if.sv =====
interface fdss_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [fdss_pkg::SAMPLE_W-1:0]    adc_sample;

  modport source(output valid, output req_type, output adc_sample, input ready);
  modport sink(input valid, input req_type, input adc_sample, output ready);
endinterface

// ===== design/fdss_out_if.sv =====
interface fdss_out_if;
  logic                           valid;
  logic                           ready;
  logic [fdss_pkg::SEG_W-1:0]     segments;
  logic [fdss_pkg::EN_W-1:0]      digit_enable;
  logic [fdss_pkg::COUNT_W-1:0]   count_value;

  modport source(output valid, output segments, output digit_enable, output count_value,
                 input ready);
  modport sink(input valid, input segments, input digit_enable, input count_value,
               output ready);
endinterface

// ===== design/fdss_counter.sv =====
module fdss_counter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             press,
  output fdss_pkg::count_t count_cur,
  output fdss_pkg::count_t count_next
);

  fdss_pkg::count_t count_r;
  fdss_pkg::count_t count_nxt;
  fdss_pkg::count_t count_inc;
  logic             carry;

  // Binary and BCD copies count together; the BCD copy wraps at 9999 by itself.
  always_comb begin
    carry = 1'b1;
    count_inc.bin = (count_r.bin >= fdss_pkg::COUNT_MAX) ? '0 : count_r.bin + 1'b1;
    for (int i = 0; i < int'(fdss_pkg::BCD_DIGITS); i++) begin
      if (carry && count_r.bcd[i] == 4'd9) begin
        count_inc.bcd[i] = 4'd0;
      end else begin
        count_inc.bcd[i] = count_r.bcd[i] + {3'd0, carry};
        carry = 1'b0;
      end
    end
    count_nxt = press ? count_inc : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_cur  = count_r;
  assign count_next = count_nxt;

endmodule

// ===== design/fdss_scan.sv =====
module fdss_scan #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  fdss_pkg::item_t  item,
  input  fdss_pkg::count_t count_cur,
  output fdss_pkg::disp_t  disp
);

  localparam int unsigned SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_DIGITS - 1);

  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [fdss_pkg::DWELL_W-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic [fdss_pkg::DWELL_W-1:0] limit_r, limit_nxt;
  fdss_pkg::bcd_t               shown_r, shown_nxt;
  logic [fdss_pkg::PROD_W-1:0]  prod;
  logic                         frame_start;
  logic [fdss_pkg::POS_W-1:0]   pos;
  fdss_pkg::bcd_digit_t         digit;

  assign frame_start = (slot_r == '0) && (ticks_r == '0);
  assign prod        = fdss_pkg::PROD_W'(item.adc_sample) * fdss_pkg::DWELL_SPAN;
  assign ticks_inc   = ticks_r + 1'b1;

  always_comb begin
    shown_nxt = shown_r;
    limit_nxt = limit_r;
    slot_nxt  = slot_r;
    ticks_nxt = ticks_r;
    if (tick) begin
      if (frame_start) begin
        shown_nxt = count_cur.bcd;
        limit_nxt = prod[fdss_pkg::PROD_W-1 -: fdss_pkg::DWELL_W] + fdss_pkg::DWELL_MIN;
      end
      // At frame start the incremented dwell is one, below any limit, so the
      // old limit gives the same answer as the freshly latched one.
      if (ticks_inc >= limit_r) begin
        ticks_nxt = '0;
        slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end else begin
        ticks_nxt = ticks_inc;
      end
    end
  end

  // Digit at the current slot, thousands first; digit positions count from the units upwards.
  always_comb begin
    pos = fdss_pkg::POS_W'(NUM_DIGITS - 1) - fdss_pkg::POS_W'(slot_r);
    digit = 4'd0;
    disp.digit_enable = '0;
    if (pos < fdss_pkg::POS_W'(fdss_pkg::BCD_DIGITS)) begin
      digit = (tick && frame_start) ? count_cur.bcd[pos[1:0]] : shown_r[pos[1:0]];
      disp.digit_enable = fdss_pkg::EN_W'(1) << pos[1:0];
    end
    disp.segments = fdss_pkg::seg_decode(digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      ticks_r <= '0;
      limit_r <= fdss_pkg::DWELL_MIN;
      shown_r <= '0;
    end else begin
      slot_r  <= slot_nxt;
      ticks_r <= ticks_nxt;
      limit_r <= limit_nxt;
      shown_r <= shown_nxt;
    end
  end

endmodule

// ===== design/four_digit_seven_segment_scanner.sv =====
// Throughput: one item per cycle while the result side keeps taking results; an
// item enters the input register, and the scan and count update runs once the
// result register is free, landing in the result register.
// Reset (rst_n low, synchronous) clears the count, shows the thousands digit,
// sets the dwell limit to six ticks and empties both registers.
module four_digit_seven_segment_scanner #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input logic        clk,
  input logic        rst_n,
  fdss_in_if.sink    in_ch,
  fdss_out_if.source out_ch
);

  // Input register: holds one item until the result register can take its result.
  logic             item_valid_r, item_valid_nxt;
  fdss_pkg::item_t  item_r;
  logic             advance;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  fdss_pkg::disp_t  disp_r;
  logic [fdss_pkg::COUNT_W-1:0] count_r;

  fdss_pkg::count_t count_cur;
  fdss_pkg::count_t count_next;
  fdss_pkg::disp_t  disp;
  logic             press;
  logic             tick;

  // The held item moves on whenever the result register is empty or being
  // emptied; the input register then refills in the same cycle, so a new item is
  // refused only while an item is held and a waiting result is not being taken.
  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;

  assign press = advance && (item_r.req_type == fdss_pkg::REQ_PRESS);
  assign tick  = advance && (item_r.req_type == fdss_pkg::REQ_TICK);

  fdss_counter u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .press      (press),
    .count_cur  (count_cur),
    .count_next (count_next)
  );

  fdss_scan #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .item      (item_r),
    .count_cur (count_cur),
    .disp      (disp)
  );

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.req_type   <= in_ch.req_type;
      item_r.adc_sample <= in_ch.adc_sample;
    end
    if (advance) begin
      disp_r  <= disp;
      count_r <= count_next.bin;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = disp_r.segments;
  assign out_ch.digit_enable = disp_r.digit_enable;
  assign out_ch.count_value  = count_r;

`ifndef NO_ASSERTIONS
  // The press count never leaves the four-digit range.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r <= fdss_pkg::COUNT_MAX))
    else $error("count_value out of range");

  // At most one digit is ever driven.
  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(disp_r.digit_enable))
    else $error("more than one digit enabled");

  // A held item that cannot move on is kept, not dropped.
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !advance) |=> item_valid_r)
    else $error("stalled item lost");

  // A tick leaves the count alone; only a press changes it.
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    tick |-> (count_next.bin == count_cur.bin))
    else $error("tick changed the count");
`endif

endmodule

// ===== tb/fdss_tb_pkg.sv =====
`timescale 1ns / 1ps
package fdss_tb_pkg;
  import fdss_pkg::*;

  localparam int unsigned SCAN_DIGITS = 4;

  // Seven-segment glyphs for 9 down to 0, so that element d is the glyph of d.
  localparam logic [9:0][SEG_W-1:0] DIGIT_GLYPH = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [EN_W-1:0]    digit_enable;
    logic [COUNT_W-1:0] count_value;
  } shown_digit_t;

  class display_scoreboard;
    logic [COUNT_W-1:0] presses;
    logic [COUNT_W-1:0] latched_value;
    int unsigned        slot;
    logic [DWELL_W-1:0] dwell_count;
    logic [DWELL_W-1:0] dwell_len;
    shown_digit_t       expected_display[$];
    int unsigned        failures;

    function new();
      presses       = '0;
      latched_value = '0;
      slot          = 0;
      dwell_count   = '0;
      dwell_len     = DWELL_MIN;
      failures      = 0;
    endfunction

    // Digit of the latched value at the current scan slot, thousands first.
    function shown_digit_t current_digit();
      shown_digit_t r;
      int unsigned  place;
      int unsigned  value;
      int unsigned  i;
      place = SCAN_DIGITS - 1 - slot;
      value = latched_value;
      for (i = 0; i < place; i++) value = value / 10;
      r.segments     = DIGIT_GLYPH[value % 10];
      r.digit_enable = '0;
      if (place < EN_W) r.digit_enable[place] = 1'b1;
      r.count_value  = presses;
      return r;
    endfunction

    function void note_item(input logic kind, input logic [SAMPLE_W-1:0] sample);
      shown_digit_t r;
      int unsigned  scaled;
      if (kind == REQ_PRESS) begin
        presses = (presses >= COUNT_MAX) ? '0 : presses + 1'b1;
        r = current_digit();
      end else begin
        // The count and the dwell are only taken up at the start of a frame.
        if (slot == 0 && dwell_count == 0) begin
          latched_value = presses;
          scaled        = (32'(sample) * 32'(DWELL_SPAN)) >> 10;
          dwell_len     = DWELL_W'(scaled + 32'(DWELL_MIN));
        end
        r = current_digit();
        dwell_count++;
        if (dwell_count >= dwell_len) begin
          dwell_count = '0;
          slot        = (slot + 1 >= SCAN_DIGITS) ? 0 : slot + 1;
        end
      end
      r.count_value = presses;
      expected_display.push_back(r);
    endfunction

    function void check_result(input shown_digit_t got);
      shown_digit_t want;
      if (expected_display.size() == 0) begin
        $error("unexpected display result: segments %h, digit_enable %h, count_value %0d",
               got.segments, got.digit_enable, got.count_value);
        failures++;
        return;
      end
      want = expected_display.pop_front();
      if (got.segments !== want.segments) begin
        $error("segments: expected %h, got %h", want.segments, got.segments);
        failures++;
      end
      if (got.digit_enable !== want.digit_enable) begin
        $error("digit_enable: expected %h, got %h", want.digit_enable, got.digit_enable);
        failures++;
      end
      if (got.count_value !== want.count_value) begin
        $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_display.size();
    endfunction
  endclass

endpackage

// ===== tb/four_digit_seven_segment_scanner_tb.sv =====
`timescale 1ns / 1ps
module four_digit_seven_segment_scanner_tb;
  import fdss_pkg::*;
  import fdss_tb_pkg::*;

  // The slowest legal run is bounded by long gaps on both sides for every item;
  // this ceiling sits well above that and only catches a hung handshake.
  localparam int unsigned CYCLE_LIMIT    = 5_000_000;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned SQUEEZE_AFTER  = 500;
  localparam int unsigned SQUEEZE_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic clk;
  logic rst_n;

  fdss_in_if  in_ch();
  fdss_out_if out_ch();

  four_digit_seven_segment_scanner #(
    .NUM_DIGITS(SCAN_DIGITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  display_scoreboard board = new();

  int unsigned tx_calm;
  int unsigned rx_calm;
  int unsigned rx_hold;
  int unsigned results_taken;
  bit          squeeze_done;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Most gaps are nothing or a few cycles; now and then a long one, so that
  // idle cycles land on every phase of the scan and of the count.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item after a random gap and returns once it has been accepted.
  // The valid line is only lowered when a gap is due, so that back-to-back
  // items keep it high without a second assignment in the same time step.
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.adc_sample <= sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(kind, sample);
  endtask

  // A level sample for a random tick: mostly short dwells so that many frames
  // go by, with the odd full-range and maximum sample.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 13) return '1;
    if (roll < 25) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 40));
  endfunction

  // Result side: takes each result at the edge where valid and ready are both
  // high, then decides ready for the next cycle. Once, after a few hundred
  // results, it holds ready low for a long stretch so that the block backs up
  // and stalls its input while the sender keeps offering items.
  initial begin
    out_ch.ready = 1'b0;
    rx_calm       = 0;
    rx_hold       = 0;
    results_taken = 0;
    squeeze_done  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_result('{segments:     out_ch.segments,
                             digit_enable: out_ch.digit_enable,
                             count_value:  out_ch.count_value});
        results_taken++;
      end
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (!squeeze_done && results_taken >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        rx_hold      = SQUEEZE_CYCLES - 1;
      end else if (rx_calm > 0) begin
        out_ch.ready <= 1'b1;
        rx_calm--;
      end else begin
        rx_hold = idle_len();
        if (rx_hold > 0) begin
          out_ch.ready <= 1'b0;
          rx_hold--;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(50, 150);
        end
      end
      @(posedge clk);
    end
  end

  // Watchdog: a run that is still going at the ceiling has hung somewhere.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("four_digit_seven_segment_scanner_tb: errors");
    $finish;
  end

  initial begin
    int unsigned i;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_TICK;
    in_ch.adc_sample = '0;
    tx_calm          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Presses before the first tick must show the thousands
    // digit of the reset value, since nothing has been latched yet. The first
    // tick opens a frame with the shortest dwell, the following ticks walk all
    // four digits with samples that must be ignored mid-frame, and the next
    // frame opens with the longest dwell.
    send_item(REQ_PRESS, '1);
    send_item(REQ_PRESS, '0);
    send_item(REQ_PRESS, 10'h155);
    send_item(REQ_TICK, '0);
    send_item(REQ_PRESS, 10'h2AA);
    for (i = 0; i < 23; i++) begin
      case (i % 4)
        0:       send_item(REQ_TICK, '1);
        1:       send_item(REQ_TICK, 10'h155);
        2:       send_item(REQ_TICK, 10'h2AA);
        default: send_item(REQ_TICK, 10'h200);
      endcase
    end
    send_item(REQ_TICK, '1);

    // Random part: mostly ticks so that the scan keeps moving, with presses
    // landing at random points of the frame.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 75) send_item(REQ_TICK, pick_sample());
      else send_item(REQ_PRESS, SAMPLE_W'($urandom));
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("four_digit_seven_segment_scanner_tb: clean");
    end else begin
      $display("four_digit_seven_segment_scanner_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fdss_pkg.sv
design/fdss_in_if.sv
design/fdss_out_if.sv
design/fdss_counter.sv
design/fdss_scan.sv
design/four_digit_seven_segment_scanner.sv
tb/fdss_tb_pkg.sv
tb/four_digit_seven_segment_scanner_tb.sv
